// ===== sv/thermistor_table_interpolator_unit_assert.svh =====
// Assertion macros for the thermistor table interpolator.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef THERMISTOR_TABLE_INTERPOLATOR_UNIT_ASSERT_SVH
`define THERMISTOR_TABLE_INTERPOLATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TTIU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ttiu assertion failed");
`define TTIU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ttiu assertion failed");
`else
`define TTIU_ASSERT(lbl, clk, rst_n, prop)
`define TTIU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/ttiu_pkg.sv =====
// Package for the thermistor table interpolator: sizes, codes and the table entry type.
// No dependencies.
package ttiu_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int SAMPLE_BITS = 12;
    localparam int TEMP_BITS   = 16;
    localparam int INDEX_BITS  = 5;
    localparam int CFG_BITS    = 6;
    localparam int REGION_BITS = 2;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int PROD_BITS   = SAMPLE_BITS + TEMP_BITS;

    localparam logic [CFG_BITS-1:0] ENTRY_COUNT_RESET = CFG_BITS'(2);

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    localparam logic [REGION_BITS-1:0] REGION_INTERP = 2'd0;
    localparam logic [REGION_BITS-1:0] REGION_BELOW  = 2'd1;
    localparam logic [REGION_BITS-1:0] REGION_BEYOND = 2'd2;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]      raw;
        logic signed [TEMP_BITS-1:0] temp;
    } t_entry;

endpackage

// ===== sv/ttiu_table_ram.sv =====
// Table memory holding the (raw, temperature) pairs, one write and one registered read port.
// Depends on ttiu_pkg.
module ttiu_table_ram (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [ttiu_pkg::IDX_BITS-1:0]  i_waddr,
    input  ttiu_pkg::t_entry               i_wdata,
    input  logic                           i_re,
    input  logic [ttiu_pkg::IDX_BITS-1:0]  i_raddr,
    output ttiu_pkg::t_entry               o_rdata
);
    import ttiu_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ttiu_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, for the interpolation step.
// Depends on ttiu_pkg and the assertion macro header.
`include "thermistor_table_interpolator_unit_assert.svh"

module ttiu_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ttiu_pkg::PROD_BITS-1:0]  i_dividend,
    input  logic [ttiu_pkg::SAMPLE_BITS-1:0] i_divisor,
    output logic                            o_done,
    output logic [ttiu_pkg::PROD_BITS-1:0]  o_quotient
);
    import ttiu_pkg::*;

    localparam int CNT_BITS = $clog2(PROD_BITS + 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic [PROD_BITS-1:0]   r_quo, n_quo;
    logic [SAMPLE_BITS-1:0] r_rem, n_rem;
    logic [SAMPLE_BITS-1:0] r_divisor, n_divisor;
    logic [SAMPLE_BITS:0]   trial;
    logic [SAMPLE_BITS:0]   diff;
    logic                   fits;

    always_comb begin
        trial = {r_rem, r_quo[PROD_BITS-1]};
        diff  = trial - {1'b0, r_divisor};
        fits  = (trial >= {1'b0, r_divisor});
    end

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cnt     = r_cnt;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        if (i_start) begin
            n_busy    = 1'b1;
            n_cnt     = CNT_BITS'(PROD_BITS);
            n_quo     = i_dividend;
            n_rem     = '0;
            n_divisor = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[PROD_BITS-2:0], fits};
            n_rem = fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `TTIU_ASSERT(a_div_start_when_free, i_clk, i_rst_n, i_start |-> !r_busy && !r_done)
    `TTIU_ASSERT(a_div_divisor_nonzero, i_clk, i_rst_n, i_start |-> i_divisor != '0)
    `TTIU_ASSERT(a_div_done_single, i_clk, i_rst_n, r_done |=> !r_done)

endmodule

// ===== sv/thermistor_table_interpolator_unit.sv =====
// Top level of the thermistor table interpolator: sequencer, table walk and output register.
// Depends on ttiu_pkg, ttiu_table_ram, ttiu_divider and the assertion macro header.
//
//  Channel  Direction  Handshake                   Payload
//  in       input      i_in_valid / o_in_stall     i_cmd, i_entry_index, i_entry_raw,
//                                                  i_entry_temp, i_sample
//  out      output     o_out_valid / i_out_stall   o_temperature, o_region
//  cfg      input      i_cfg_we                    i_cfg_wdata (entry_count)
//
// A write transaction goes straight to the table memory. A convert transaction reads the
// table from entry 0 until the sample is placed; a sample outside the table ends without a
// division. The table memory is read one entry per cycle, and an interpolated sample then
// goes through the divider, which produces one quotient bit per cycle.
// Reset is synchronous; the table contents are undefined until written and are not cleared.
// The next transaction is accepted while a finished result waits in the output register;
// a result stalled on the output holds the sequencer in its final state.
`include "thermistor_table_interpolator_unit_assert.svh"

module thermistor_table_interpolator_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [ttiu_pkg::CFG_BITS-1:0]            i_cfg_wdata,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic                                     i_cmd,
    input  logic [ttiu_pkg::INDEX_BITS-1:0]          i_entry_index,
    input  logic [ttiu_pkg::SAMPLE_BITS-1:0]         i_entry_raw,
    input  logic signed [ttiu_pkg::TEMP_BITS-1:0]    i_entry_temp,
    input  logic [ttiu_pkg::SAMPLE_BITS-1:0]         i_sample,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [ttiu_pkg::TEMP_BITS-1:0]    o_temperature,
    output logic [ttiu_pkg::REGION_BITS-1:0]         o_region
);
    import ttiu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam int SUM_BITS = TEMP_BITS + 2;

    logic [2:0]                   r_state, n_state;
    logic [CFG_BITS-1:0]          r_entry_count, n_entry_count;
    logic [SAMPLE_BITS-1:0]       r_sample, n_sample;
    logic [IDX_BITS-1:0]          r_last, n_last;
    logic [IDX_BITS-1:0]          r_k, n_k;
    logic [SAMPLE_BITS-1:0]       r_old_raw, n_old_raw;
    logic signed [TEMP_BITS-1:0]  r_old_temp, n_old_temp;
    logic [SAMPLE_BITS-1:0]       r_dsamp, n_dsamp;
    logic [TEMP_BITS-1:0]         r_dtemp_mag, n_dtemp_mag;
    logic                         r_neg, n_neg;
    logic [SAMPLE_BITS-1:0]       r_divisor, n_divisor;
    logic signed [TEMP_BITS-1:0]  r_res_temp, n_res_temp;
    logic [REGION_BITS-1:0]       r_res_region, n_res_region;
    logic                         r_out_valid, n_out_valid;
    logic signed [TEMP_BITS-1:0]  r_out_temp, n_out_temp;
    logic [REGION_BITS-1:0]       r_out_region, n_out_region;

    logic                         in_accept;
    logic [IDX_BITS-1:0]          last_clamp;
    logic                         ram_we;
    logic [IDX_BITS-1:0]          ram_waddr;
    t_entry                       ram_wdata;
    logic                         ram_re;
    logic [IDX_BITS-1:0]          ram_raddr;
    t_entry                       rd;
    logic [TEMP_BITS:0]           dtemp;
    logic                         div_start;
    logic [PROD_BITS-1:0]         div_dividend;
    logic                         div_done;
    logic [PROD_BITS-1:0]         div_quotient;
    logic [SUM_BITS-1:0]          q_ext;
    logic [SUM_BITS-1:0]          q_signed;
    logic [SUM_BITS-1:0]          interp_sum;
    logic                         out_load;

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_entry_count == '0) begin
            last_clamp = '0;
        end else if (32'(r_entry_count) > TABLE_DEPTH) begin
            last_clamp = IDX_BITS'(TABLE_DEPTH - 1);
        end else begin
            last_clamp = IDX_BITS'(r_entry_count - 1'b1);
        end
    end

    assign ram_we         = in_accept && (i_cmd == CMD_WRITE)
                            && (32'(i_entry_index) < TABLE_DEPTH);
    assign ram_waddr      = IDX_BITS'(i_entry_index);
    assign ram_wdata.raw  = i_entry_raw;
    assign ram_wdata.temp = i_entry_temp;

    ttiu_table_ram u_table_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    assign div_start    = (r_state == S_MUL);
    assign div_dividend = PROD_BITS'(r_dsamp) * PROD_BITS'(r_dtemp_mag);

    ttiu_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_comb begin
        dtemp      = {rd.temp[TEMP_BITS-1], rd.temp} - {r_old_temp[TEMP_BITS-1], r_old_temp};
        q_ext      = {2'b00, div_quotient[TEMP_BITS-1:0]};
        q_signed   = r_neg ? (SUM_BITS'(0) - q_ext) : q_ext;
        interp_sum = {{2{r_old_temp[TEMP_BITS-1]}}, r_old_temp} + q_signed;
    end

    always_comb begin
        n_state       = r_state;
        n_entry_count = r_entry_count;
        n_sample      = r_sample;
        n_last        = r_last;
        n_k           = r_k;
        n_old_raw     = r_old_raw;
        n_old_temp    = r_old_temp;
        n_dsamp       = r_dsamp;
        n_dtemp_mag   = r_dtemp_mag;
        n_neg         = r_neg;
        n_divisor     = r_divisor;
        n_res_temp    = r_res_temp;
        n_res_region  = r_res_region;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        if (i_cfg_we) begin
            n_entry_count = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_cmd == CMD_CONVERT)) begin
                    n_sample  = i_sample;
                    n_last    = last_clamp;
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                    n_state   = S_RD0;
                end
            end
            S_RD0: begin
                n_old_raw  = rd.raw;
                n_old_temp = rd.temp;
                n_res_temp = rd.temp;
                if (rd.raw > r_sample) begin
                    n_res_region = REGION_BELOW;
                    n_state      = S_FIN;
                end else if (r_last == '0) begin
                    n_res_region = REGION_BEYOND;
                    n_state      = S_FIN;
                end else begin
                    n_k       = IDX_BITS'(1);
                    ram_re    = 1'b1;
                    ram_raddr = IDX_BITS'(1);
                    n_state   = S_WALK;
                end
            end
            S_WALK: begin
                if (rd.raw > r_sample) begin
                    n_dsamp     = r_sample - r_old_raw;
                    n_divisor   = rd.raw - r_old_raw;
                    n_neg       = dtemp[TEMP_BITS];
                    n_dtemp_mag = dtemp[TEMP_BITS] ? TEMP_BITS'(-dtemp) : dtemp[TEMP_BITS-1:0];
                    n_state     = S_MUL;
                end else if (r_k == r_last) begin
                    n_res_temp   = rd.temp;
                    n_res_region = REGION_BEYOND;
                    n_state      = S_FIN;
                end else begin
                    n_old_raw  = rd.raw;
                    n_old_temp = rd.temp;
                    n_k        = r_k + 1'b1;
                    ram_re     = 1'b1;
                    ram_raddr  = r_k + 1'b1;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_res_temp   = interp_sum[TEMP_BITS-1:0];
                    n_res_region = REGION_INTERP;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_temp   = r_out_temp;
        n_out_region = r_out_region;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid  = 1'b1;
            n_out_temp   = r_res_temp;
            n_out_region = r_res_region;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= ENTRY_COUNT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_entry_count <= n_entry_count;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample     <= n_sample;
        r_last       <= n_last;
        r_k          <= n_k;
        r_old_raw    <= n_old_raw;
        r_old_temp   <= n_old_temp;
        r_dsamp      <= n_dsamp;
        r_dtemp_mag  <= n_dtemp_mag;
        r_neg        <= n_neg;
        r_divisor    <= n_divisor;
        r_res_temp   <= n_res_temp;
        r_res_region <= n_res_region;
        r_out_temp   <= n_out_temp;
        r_out_region <= n_out_region;
    end

    assign o_out_valid   = r_out_valid;
    assign o_temperature = r_out_temp;
    assign o_region      = r_out_region;

    `TTIU_ASSERT(a_walk_in_bounds, i_clk, i_rst_n, r_state == S_WALK |-> r_k != '0 && r_k <= r_last)
    `TTIU_ASSERT(a_table_write_idle, i_clk, i_rst_n, ram_we |-> r_state == S_IDLE && !ram_re)
    `TTIU_ASSERT(a_div_done_in_div, i_clk, i_rst_n, div_done |-> r_state == S_DIV)
    `TTIU_ASSERT(a_convert_starts_walk, i_clk, i_rst_n, in_accept && i_cmd == CMD_CONVERT |=> r_state == S_RD0)

endmodule
